// File: rtl/msgr_pkg.sv
// ----------------------------------------------------------------------------
// msgr_pkg
// Shared types and codes for the message match ring: transaction payloads,
// ring entry layout, command and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package msgr_pkg;

  // Command codes carried in the cmd field
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  // Result status codes
  localparam logic [1:0] STS_ADDED   = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_MATCH   = 2'd2;
  localparam logic [1:0] STS_NOMATCH = 2'd3;

  // Input transaction
  typedef struct packed {
    logic               cmd;
    logic [1:0]         role;
    logic [7:0]         node;
    logic               any_node;
    logic [7:0]         dest_node;
    logic [31:0]        ticket;
    logic [7:0]         msg_type;
    logic [31:0]        slot;
    logic               any_slot;
    logic [7:0]         type_mask;
    logic signed [63:0] value;
  } msgr_in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         out_from;
    logic [7:0]         out_to;
    logic [31:0]        out_ticket;
    logic [7:0]         out_type;
    logic [31:0]        out_slot;
    logic signed [63:0] out_value;
  } msgr_out_t;

  // One ring entry as stored in the ring memory
  typedef struct packed {
    logic               valid;
    logic [7:0]         sender;
    logic [7:0]         dest;
    logic [31:0]        ticket;
    logic [7:0]         kind;
    logic [31:0]        slot;
    logic signed [63:0] payload;
  } msgr_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // clearing pass: invalidate one entry
    logic start;   // capture transaction, load scan pointer
    logic scan;    // issue reads and check entries
    logic finish;  // commit writes, pointers and result
  } msgr_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // clearing pass on last entry
    logic scan_done;  // scan stopped on a hit or finished its lap
    logic out_free;   // result register can take a new result
  } msgr_sts_t;

endpackage

// File: rtl/msgr_stream_if.sv
// ----------------------------------------------------------------------------
// msgr_stream_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface msgr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/msgr_ram.sv
// ----------------------------------------------------------------------------
// msgr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module msgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: rtl/msgr_ctrl.sv
// ----------------------------------------------------------------------------
// msgr_ctrl
// Sequencer for the message match ring: clearing pass after reset, then
// accept, scan, finish for one transaction at a time.
// ----------------------------------------------------------------------------
module msgr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output msgr_pkg::msgr_ctl_t ctl,
  input  msgr_pkg::msgr_sts_t sts
);
  import msgr_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Decode state into commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Wait for room in the result register
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/msgr_dp.sv
// ----------------------------------------------------------------------------
// msgr_dp
// Datapath of the message match ring: ring memory, scan address and
// check pipeline, write and reader pointers, result register.
// ----------------------------------------------------------------------------
module msgr_dp #(
  parameter int RING_DEPTH = 64,
  parameter int NUM_ROLES  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  msgr_pkg::msgr_ctl_t ctl,
  output msgr_pkg::msgr_sts_t sts,
  input  msgr_pkg::msgr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output msgr_pkg::msgr_out_t out_data
);
  import msgr_pkg::*;

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int CW  = $clog2(RING_DEPTH + 1);
  localparam int RIW = (NUM_ROLES > 1) ? $clog2(NUM_ROLES) : 1;
  localparam int EW  = $bits(msgr_entry_t);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] LAP_LEN   = CW'(RING_DEPTH);

  // Transaction and scan state
  msgr_in_t      item_r;
  logic [AW-1:0] rd_addr_r;
  logic [CW-1:0] issue_cnt_r;
  logic          chk_vld_r;
  logic [AW-1:0] chk_addr_r;
  logic          first_fnd_r;
  logic [AW-1:0] first_addr_r;
  logic          hit_fnd_r;
  logic [AW-1:0] hit_addr_r;

  // Pointers
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r [NUM_ROLES];

  // Result register
  logic          out_valid_r;
  msgr_out_t     out_data_r;
  msgr_out_t     out_data_nxt;

  // Memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  msgr_entry_t   ram_wentry;
  logic          ram_re;
  logic [EW-1:0] ram_rdata;
  msgr_entry_t   rd_ent;

  logic          is_add;
  logic          in_role_ok;
  logic [RIW-1:0] in_role_idx;
  logic [RIW-1:0] item_role_idx;
  logic [AW-1:0] start_ptr;
  logic [AW-1:0] rd_addr_inc;
  logic          ent_match;
  logic          hit_now;
  logic          lap_done;

  assign is_add        = (item_r.cmd == CMD_ADD);
  assign in_role_ok    = (32'(in_data.role) < NUM_ROLES);
  assign in_role_idx   = RIW'(in_data.role);
  assign item_role_idx = RIW'(item_r.role);
  assign rd_ent        = msgr_entry_t'(ram_rdata);
  assign rd_addr_inc   = (rd_addr_r == LAST_ADDR) ? '0 : rd_addr_r + AW'(1);

  // Pick the pointer a new transaction starts from
  always_comb begin
    if (in_data.cmd == CMD_ADD) begin
      start_ptr = wp_r;
    end else if (in_role_ok) begin
      start_ptr = rp_r[in_role_idx];
    end else begin
      start_ptr = '0;
    end
  end

  // Check the entry read last cycle
  assign ent_match = rd_ent.valid
                  && (item_r.any_node || (rd_ent.sender == item_r.node))
                  && (item_r.any_slot || (rd_ent.slot == item_r.slot))
                  && ((rd_ent.kind & item_r.type_mask) != 8'd0);
  assign hit_now   = chk_vld_r && (is_add ? (!rd_ent.valid && first_fnd_r) : ent_match);
  assign lap_done  = (issue_cnt_r == LAP_LEN) && !chk_vld_r;
  assign ram_re    = ctl.scan && (issue_cnt_r != LAP_LEN) && !hit_now;

  assign sts.clr_last  = (rd_addr_r == LAST_ADDR);
  assign sts.scan_done = hit_now || lap_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  // Memory write port: clearing pass, add store, receive clear
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = rd_addr_r;
    ram_wentry = '0;
    if (ctl.clear) begin
      ram_we = 1'b1;
    end else if (ctl.finish) begin
      if (is_add) begin
        ram_we             = first_fnd_r;
        ram_waddr          = first_addr_r;
        ram_wentry.valid   = 1'b1;
        ram_wentry.sender  = item_r.node;
        ram_wentry.dest    = item_r.dest_node;
        ram_wentry.ticket  = item_r.ticket;
        ram_wentry.kind    = item_r.msg_type;
        ram_wentry.slot    = item_r.slot;
        ram_wentry.payload = item_r.value;
      end else begin
        ram_we    = hit_fnd_r;
        ram_waddr = hit_addr_r;
      end
    end
  end

  msgr_ram #(
    .WIDTH (EW),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wentry)),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // Build the result
  always_comb begin
    out_data_nxt = '0;
    if (is_add) begin
      out_data_nxt.status = first_fnd_r ? STS_ADDED : STS_FULL;
    end else if (hit_fnd_r) begin
      out_data_nxt.status     = STS_MATCH;
      out_data_nxt.out_from   = rd_ent.sender;
      out_data_nxt.out_to     = rd_ent.dest;
      out_data_nxt.out_ticket = rd_ent.ticket;
      out_data_nxt.out_type   = rd_ent.kind;
      out_data_nxt.out_slot   = rd_ent.slot;
      out_data_nxt.out_value  = rd_ent.payload;
    end else begin
      out_data_nxt.status = STS_NOMATCH;
    end
  end

  // Capture transaction payload
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      item_r <= in_data;
    end
  end

  // Scan address, check pipeline and found flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r   <= '0;
      issue_cnt_r <= '0;
      chk_vld_r   <= 1'b0;
      first_fnd_r <= 1'b0;
      hit_fnd_r   <= 1'b0;
    end else begin
      if (ctl.clear) begin
        rd_addr_r <= rd_addr_inc;
      end else if (ctl.start) begin
        rd_addr_r   <= start_ptr;
        issue_cnt_r <= (in_data.cmd == CMD_ADD || in_role_ok) ? '0 : LAP_LEN;
        chk_vld_r   <= 1'b0;
        first_fnd_r <= 1'b0;
        hit_fnd_r   <= 1'b0;
      end else if (ctl.scan) begin
        chk_vld_r <= ram_re;
        if (ram_re) begin
          rd_addr_r   <= rd_addr_inc;
          issue_cnt_r <= issue_cnt_r + CW'(1);
        end
        if (chk_vld_r && is_add && !rd_ent.valid && !first_fnd_r) begin
          first_fnd_r <= 1'b1;
        end
        if (hit_now) begin
          hit_fnd_r <= 1'b1;
        end
      end
    end
  end

  // Found addresses
  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      chk_addr_r <= rd_addr_r;
      if (chk_vld_r && is_add && !rd_ent.valid && !first_fnd_r) begin
        first_addr_r <= chk_addr_r;
      end
      if (hit_now) begin
        hit_addr_r <= chk_addr_r;
      end
    end
  end

  // Advance write pointer and reader pointers on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      for (int r = 0; r < NUM_ROLES; r++) begin
        rp_r[r] <= LAST_ADDR;
      end
    end else if (ctl.finish) begin
      if (is_add) begin
        if (first_fnd_r) begin
          wp_r <= hit_fnd_r ? hit_addr_r : first_addr_r;
        end
      end else if (hit_fnd_r) begin
        rp_r[item_role_idx] <= hit_addr_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/message_match_ring.sv
// ----------------------------------------------------------------------------
// message_match_ring
// Ring of message entries with one write pointer and per-role read
// pointers; adds store a message, receives take the first matching one.
// ----------------------------------------------------------------------------
//   channel | dir | payload     | transaction when
//   in_ch   | in  | msgr_in_t   | valid && ready
//   out_ch  | out | msgr_out_t  | valid && ready
//
// After its accept a transaction scans the ring from its start pointer: it
// issues one ring memory read per address over one lap, checks the last read,
// closes the lap, then commits once the result register has room. The next
// accept follows the commit. The single read port of the ring memory bounds
// the scan; a scan stops early on its hit.
// After reset a clearing pass invalidates every entry;
// in_ch.ready stays low meanwhile.
// The next transaction is accepted while a result waits on out_ch; a stalled
// result holds the following one in its commit cycle.
module message_match_ring #(
  parameter int RING_DEPTH = 64,
  parameter int NUM_ROLES  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  msgr_stream_if.sink          in_ch,
  msgr_stream_if.source        out_ch
);
  import msgr_pkg::*;

  msgr_ctl_t ctl;
  msgr_sts_t sts;
  logic      in_ready;

  msgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .ctl      (ctl),
    .sts      (sts)
  );

  msgr_dp #(
    .RING_DEPTH (RING_DEPTH),
    .NUM_ROLES  (NUM_ROLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

  assign in_ch.ready = in_ready;

endmodule

// File: rtl/msgr_checker.sv
// ----------------------------------------------------------------------------
// msgr_checker
// Port-level checks for the message match ring, bound to the top level.
// ----------------------------------------------------------------------------
module msgr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input msgr_pkg::msgr_out_t out_data
);
  import msgr_pkg::*;

  logic [1:0] pending_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count transactions accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  // A result only answers an accepted transaction
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 2'd0))
    else $error("result without an outstanding transaction");

  // Adds and failed receives carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STS_MATCH)) |->
      (out_data.out_from == 8'd0 && out_data.out_to == 8'd0 &&
       out_data.out_ticket == 32'd0 && out_data.out_type == 8'd0 &&
       out_data.out_slot == 32'd0 && out_data.out_value == 64'sd0))
    else $error("non-match result carries data");

  // A matched message has at least one type bit set
  a_match_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STS_MATCH)) |-> (out_data.out_type != 8'd0))
    else $error("matched message with empty type");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // Clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input accepted right after reset");

endmodule

bind message_match_ring msgr_checker u_msgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for message_match_ring. A directed table covers the
// empty ring, field extremes and each way a receive can miss. Random traffic
// then fills the ring to overflow and drains it again. Every result is checked
// against a transaction-level ring predictor, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msgr_pkg::*;

  localparam int RING   = 64;
  localparam int ROLES  = 4;
  localparam int RAND_N = 1100;
  localparam int LIMIT  = 1_500_000;
  localparam int DIR_N  = 18;

  localparam logic [7:0]  NODE_POOL [4] = '{8'h00, 8'h5A, 8'hA5, 8'hFF};
  localparam logic [31:0] SLOT_POOL [4] = '{32'h0, 32'h1, 32'h8000_0000, 32'hFFFF_FFFF};

  // One directed row; want is used only where typed is set
  typedef struct packed {
    msgr_in_t  stim;
    logic      typed;
    msgr_out_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  msgr_stream_if #(.T(msgr_in_t))  in_if ();
  msgr_stream_if #(.T(msgr_out_t)) out_if ();

  message_match_ring #(
    .RING_DEPTH(RING),
    .NUM_ROLES(ROLES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // Predictor state: ring contents and pointers
  msgr_entry_t ring_mem [RING];
  int          add_ptr;
  int          role_ptr [ROLES];

  msgr_out_t   pending_res [$];
  int          err_cnt;
  int          cycles;
  bit          quiet;

  function automatic msgr_in_t mk_add(input logic [7:0] node, input logic [7:0] dest,
                                      input logic [31:0] ticket, input logic [7:0] kind,
                                      input logic [31:0] slot, input logic signed [63:0] value);
    msgr_in_t t;
    t           = '0;
    t.cmd       = CMD_ADD;
    t.node      = node;
    t.dest_node = dest;
    t.ticket    = ticket;
    t.msg_type  = kind;
    t.slot      = slot;
    t.value     = value;
    return t;
  endfunction

  function automatic msgr_in_t mk_recv(input logic [1:0] role, input logic [7:0] node,
                                       input logic any_node, input logic [31:0] slot,
                                       input logic any_slot, input logic [7:0] mask);
    msgr_in_t t;
    t           = '0;
    t.cmd       = CMD_RECV;
    t.role      = role;
    t.node      = node;
    t.any_node  = any_node;
    t.slot      = slot;
    t.any_slot  = any_slot;
    t.type_mask = mask;
    return t;
  endfunction

  function automatic msgr_out_t mk_res(input logic [1:0] status, input logic [7:0] from,
                                       input logic [7:0] to, input logic [31:0] ticket,
                                       input logic [7:0] kind, input logic [31:0] slot,
                                       input logic signed [63:0] value);
    msgr_out_t r;
    r.status     = status;
    r.out_from   = from;
    r.out_to     = to;
    r.out_ticket = ticket;
    r.out_type   = kind;
    r.out_slot   = slot;
    r.out_value  = value;
    return r;
  endfunction

  function automatic msgr_out_t bare_res(input logic [1:0] status);
    msgr_out_t r;
    r        = '0;
    r.status = status;
    return r;
  endfunction

  // Directed stimulus; untyped rows rely on the predictor
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty ring
    '{mk_recv(2'd0, 8'h00, 1'b1, 32'h0, 1'b1, 8'hFF), 1'b1, bare_res(STS_NOMATCH)},
    // field extremes
    '{mk_add(8'h00, 8'h00, 32'h0, 8'hFF, 32'h0, 64'sh8000_0000_0000_0000),
      1'b1, bare_res(STS_ADDED)},
    '{mk_add(8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'h01, 32'hFFFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFFF),
      1'b1, bare_res(STS_ADDED)},
    '{mk_recv(2'd0, 8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 8'h01), 1'b1,
      mk_res(STS_MATCH, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'h01, 32'hFFFF_FFFF,
             64'sh7FFF_FFFF_FFFF_FFFF)},
    // zero mask never matches
    '{mk_recv(2'd1, 8'h00, 1'b1, 32'h0, 1'b1, 8'h00), 1'b1, bare_res(STS_NOMATCH)},
    '{mk_recv(2'd1, 8'h00, 1'b1, 32'h0, 1'b1, 8'h80), 1'b1,
      mk_res(STS_MATCH, 8'h00, 8'h00, 32'h0, 8'hFF, 32'h0, 64'sh8000_0000_0000_0000)},
    '{mk_recv(2'd2, 8'h00, 1'b1, 32'h0, 1'b1, 8'hFF), 1'b1, bare_res(STS_NOMATCH)},
    // role pointers walk and wrap
    '{mk_add(8'h11, 8'h01, 32'h10, 8'h02, 32'h5, 64'sd10), 1'b0, '0},
    '{mk_add(8'h22, 8'h02, 32'h20, 8'h04, 32'h5, 64'sd20), 1'b0, '0},
    '{mk_add(8'h11, 8'h03, 32'h30, 8'h06, 32'h7, 64'sd30), 1'b0, '0},
    '{mk_recv(2'd0, 8'h11, 1'b0, 32'h7, 1'b0, 8'h02), 1'b0, '0},
    '{mk_recv(2'd0, 8'h11, 1'b0, 32'h0, 1'b1, 8'h02), 1'b0, '0},
    // slot, type and sender misses
    '{mk_recv(2'd3, 8'h22, 1'b0, 32'h6, 1'b0, 8'hFF), 1'b1, bare_res(STS_NOMATCH)},
    '{mk_recv(2'd3, 8'h22, 1'b0, 32'h5, 1'b0, 8'h0B), 1'b1, bare_res(STS_NOMATCH)},
    '{mk_recv(2'd3, 8'h23, 1'b0, 32'h0, 1'b1, 8'hFF), 1'b1, bare_res(STS_NOMATCH)},
    '{mk_recv(2'd3, 8'h00, 1'b1, 32'h5, 1'b0, 8'h04), 1'b0, '0},
    // payload of all ones
    '{mk_add(8'h3C, 8'hC3, 32'h1234_5678, 8'h10, 32'h5, -64'sd1), 1'b1, bare_res(STS_ADDED)},
    '{mk_recv(2'd2, 8'h00, 1'b1, 32'h0, 1'b1, 8'hFF), 1'b1,
      mk_res(STS_MATCH, 8'h3C, 8'hC3, 32'h1234_5678, 8'h10, 32'h5, -64'sd1)}
  };

  // Advance the predicted ring by one transaction and return its result
  function automatic msgr_out_t ring_step(input msgr_in_t t);
    msgr_out_t r;
    int        p, q, n, ro;
    bit        hit;
    r   = '0;
    hit = 1'b0;
    if (t.cmd == CMD_ADD) begin
      r.status = STS_FULL;
      p = add_ptr;
      for (n = 0; n < RING; n++) begin
        if (!ring_mem[p].valid) begin
          hit = 1'b1;
          break;
        end
        p = (p + 1) % RING;
      end
      if (hit) begin
        ring_mem[p].valid   = 1'b1;
        ring_mem[p].sender  = t.node;
        ring_mem[p].dest    = t.dest_node;
        ring_mem[p].ticket  = t.ticket;
        ring_mem[p].kind    = t.msg_type;
        ring_mem[p].slot    = t.slot;
        ring_mem[p].payload = t.value;
        // park on the next free entry, or stay put when none is left
        add_ptr = p;
        for (n = 1; n < RING; n++) begin
          q = (p + n) % RING;
          if (!ring_mem[q].valid) begin
            add_ptr = q;
            break;
          end
        end
        r.status = STS_ADDED;
      end
    end else begin
      r.status = STS_NOMATCH;
      ro = int'(t.role);
      if (ro < ROLES) begin
        p = role_ptr[ro];
        for (n = 0; n < RING; n++) begin
          if (ring_mem[p].valid
              && (t.any_node || ring_mem[p].sender == t.node)
              && (t.any_slot || ring_mem[p].slot == t.slot)
              && ((ring_mem[p].kind & t.type_mask) != 8'h00)) begin
            ring_mem[p].valid = 1'b0;
            role_ptr[ro]      = p;
            r = mk_res(STS_MATCH, ring_mem[p].sender, ring_mem[p].dest, ring_mem[p].ticket,
                       ring_mem[p].kind, ring_mem[p].slot, ring_mem[p].payload);
            break;
          end
          p = (p + 1) % RING;
        end
      end
    end
    return r;
  endfunction

  // Random transaction; most receives aim at a message now in the ring
  function automatic msgr_in_t gen_item(input int add_pct);
    msgr_in_t t;
    int       p, n;
    t.cmd       = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_RECV;
    t.role      = 2'($urandom);
    t.node      = ($urandom_range(3) == 0) ? 8'($urandom) : NODE_POOL[$urandom_range(3)];
    t.any_node  = ($urandom_range(2) == 0);
    t.dest_node = 8'($urandom);
    t.ticket    = $urandom;
    t.msg_type  = 8'($urandom);
    t.slot      = ($urandom_range(3) == 0) ? 32'($urandom) : SLOT_POOL[$urandom_range(3)];
    t.any_slot  = ($urandom_range(2) == 0);
    t.type_mask = 8'($urandom);
    t.value     = {$urandom, $urandom};
    if (t.cmd == CMD_RECV && $urandom_range(99) < 70) begin
      p = $urandom_range(RING - 1);
      for (n = 0; n < RING; n++) begin
        if (ring_mem[p].valid) break;
        p = (p + 1) % RING;
      end
      if (ring_mem[p].valid) begin
        t.node       = ring_mem[p].sender;
        t.slot       = ring_mem[p].slot;
        t.type_mask |= ring_mem[p].kind & (~ring_mem[p].kind + 8'd1);
      end
    end
    return t;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(100, 30);
  endfunction

  task automatic flag_field(input string name, input logic [63:0] exp_v,
                            input logic [63:0] act_v);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
  endtask

  // Compare one result transaction with the oldest expectation
  task automatic check_result(input msgr_out_t got);
    msgr_out_t want;
    if (pending_res.size() == 0) begin
      flag_field("unexpected result, status", 64'h0, 64'(got.status));
      return;
    end
    want = pending_res.pop_front();
    if (got.status !== want.status)
      flag_field("status", 64'(want.status), 64'(got.status));
    if (got.out_from !== want.out_from)
      flag_field("out_from", 64'(want.out_from), 64'(got.out_from));
    if (got.out_to !== want.out_to)
      flag_field("out_to", 64'(want.out_to), 64'(got.out_to));
    if (got.out_ticket !== want.out_ticket)
      flag_field("out_ticket", 64'(want.out_ticket), 64'(got.out_ticket));
    if (got.out_type !== want.out_type)
      flag_field("out_type", 64'(want.out_type), 64'(got.out_type));
    if (got.out_slot !== want.out_slot)
      flag_field("out_slot", 64'(want.out_slot), 64'(got.out_slot));
    if (got.out_value !== want.out_value)
      flag_field("out_value", want.out_value, got.out_value);
  endtask

  // Drive one transaction, hold it until accepted, then predict its result
  task automatic send_item(input msgr_in_t t, input logic typed, input msgr_out_t want);
    msgr_out_t predicted;
    int        gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = ring_step(t);
    pending_res.push_back(typed ? want : predicted);
  endtask

  // Hold off the sender until every result has come back
  task automatic park_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_res.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result side: random back-pressure, check every accepted transaction
  initial begin : result_sink
    int stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) check_result(out_if.data);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int i;
    int add_pct;
    err_cnt = 0;
    quiet   = 1'b0;
    add_ptr = 0;
    foreach (ring_mem[k]) ring_mem[k] = '0;
    foreach (role_ptr[k]) role_ptr[k] = RING - 1;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    rst_n       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_N; i++)
      send_item(DIR_ROWS[i].stim, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    park_until_drained();

    // Rotate between balanced, filling and draining traffic
    for (i = 0; i < RAND_N; i++) begin
      quiet = (i % 200) >= 170;
      case ((i / 120) % 3)
        0:       add_pct = 50;
        1:       add_pct = 85;
        default: add_pct = 20;
      endcase
      if (i == RAND_N / 3 || i == 2 * RAND_N / 3) park_until_drained();
      send_item(gen_item(add_pct), 1'b0, '0);
    end

    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_res.size() != 0);
    repeat (RING + 8) @(posedge clk);
    if (err_cnt == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
